### rtl/ncmg_pkg.sv
// Shared constants, types and helpers for the noise cave map generator.
`timescale 1ns / 1ps

package ncmg_pkg;

   localparam int MAP_COLUMNS = 40;
   localparam int MAP_ROWS    = 40;

   localparam int COL_W  = $clog2(MAP_COLUMNS);
   localparam int ROW_W  = $clog2(MAP_ROWS);
   localparam int ADDR_W = $clog2(MAP_COLUMNS * MAP_ROWS);
   localparam int DEPTH  = MAP_COLUMNS * MAP_ROWS;
   localparam int TILE_W = 2;
   localparam int HASH_W = 31;

   // hash constants
   localparam logic [31:0] HASH_ROW_MUL  = 32'd57;
   localparam logic [31:0] HASH_SEED_MUL = 32'd131;
   localparam int          HASH_SHIFT    = 13;
   localparam logic [31:0] HASH_SQ_MUL   = 32'd15731;
   localparam logic [31:0] HASH_SQ_ADD   = 32'd789221;
   localparam logic [31:0] HASH_FIN_ADD  = 32'd1376312589;

   // tile codes
   localparam logic [TILE_W-1:0] TILE_NONE  = 2'd0;
   localparam logic [TILE_W-1:0] TILE_WATER = 2'd1;
   localparam logic [TILE_W-1:0] TILE_ICE   = 2'd2;
   localparam logic [TILE_W-1:0] TILE_ROCK  = 2'd3;

   // operations and reply kinds
   localparam logic OP_GENERATE   = 1'b0;
   localparam logic OP_READ       = 1'b1;
   localparam logic REPLY_DONE    = 1'b0;
   localparam logic REPLY_TILE    = 1'b1;

   // register indexes
   localparam logic [1:0] REG_ICE_LIMIT   = 2'd0;
   localparam logic [1:0] REG_ROCK_LIMIT  = 2'd1;
   localparam logic [1:0] REG_PASSES      = 2'd2;
   localparam logic [1:0] REG_WATER_LIMIT = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_DRAIN,
      ST_COL_START,
      ST_FETCH,
      ST_COMPUTE,
      ST_DONE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [HASH_W-1:0] hash;
   } hash_out_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [COL_W-1:0] c,
                                                 input logic [ROW_W-1:0] r);
      return ADDR_W'(int'(c) * MAP_ROWS + int'(r));
   endfunction

endpackage

### rtl/noise_cave_map_generator.sv
// Top level: request handling, fill and smoothing sequencer, configuration registers.
`timescale 1ns / 1ps

// A generate item fills the 40x40 tile store from a noise hash of (column, row,
// seed) through a pipelined hash unit, one tile a cycle, then runs
// smoothing_passes in-place passes. Each smoothed tile costs a fetch of one
// neighbour row (up to three reads through the store's single read port) and
// a compute/write state; the store read port sets the pace of a pass. A
// generate answers with one done item (tile 0). A tile read answers in the
// cycle after acceptance when it is outside the map or comes before any
// generate (tile 0), and otherwise reads the store and answers from ST_READ.
// One item is worked on at a time.

module noise_cave_map_generator (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // seed[31:0], column[37:32], row[43:38], zero fill
   input  logic        req_tuser,   // operation
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // tile[1:0], zero fill
   output logic        rsp_tuser,   // reply_kind
   // configuration
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int CW = ncmg_pkg::COL_W;
   localparam int RW = ncmg_pkg::ROW_W;
   localparam int AW = ncmg_pkg::ADDR_W;
   localparam int TW = ncmg_pkg::TILE_W;

   // config
   logic [31:0] ice_limit_ff, rock_limit_ff;
   logic [3:0]  passes_ff, water_limit_ff;

   ncmg_pkg::state_type state_ff, state_in;

   logic [31:0]   seed_ff, seed_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW:0]   frow_ff, frow_in;     // neighbour row being fetched
   logic [1:0]    sub_ff, sub_in;
   logic [3:0]    pass_ff, pass_in;
   logic          rd_ok_ff, rd_ok_in;
   logic          generated_ff, generated_in;
   logic [TW-1:0] win_ff [3][3];        // [column c-1..c+1][row r-1..r+1]
   logic [TW-1:0] win_in [3][3];
   logic [TW-1:0] nrow_ff [2];
   logic [TW-1:0] nrow_in [2];

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [TW-1:0] rsp_tile_ff, rsp_tile_in;

   // store ports
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [TW-1:0] wr_data, rd_data;

   // hash unit
   logic                   hash_in_valid, hash_busy;
   ncmg_pkg::hash_out_type hash_out;
   logic [TW-1:0]          hash_code;

   // request fields
   logic [31:0] req_seed;
   logic [5:0]  req_column, req_row;
   logic        req_fire, in_map;

   // smoothing helpers
   logic [CW:0]   fcol;
   logic          fvalid;
   logic [TW-1:0] fdata;
   logic [3:0]    water_cnt;
   logic [TW-1:0] new_tile;
   logic [4:0]    pass_next;

   assign req_seed   = req_tdata[31:0];
   assign req_column = req_tdata[37:32];
   assign req_row    = req_tdata[43:38];
   assign req_tready = (state_ff == ncmg_pkg::ST_IDLE) && !rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign in_map     = (7'(req_column) < 7'(ncmg_pkg::MAP_COLUMNS))
                    && (7'(req_row) < 7'(ncmg_pkg::MAP_ROWS));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = 8'(rsp_tile_ff);

   ncmg_hash u_hash (
      .clock    (clock),
      .reset    (reset),
      .in_valid (hash_in_valid),
      .in_col   (col_ff),
      .in_row   (row_ff),
      .seed     (seed_ff),
      .hash_out (hash_out),
      .busy     (hash_busy)
   );

   ncmg_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // classify the hash
   always_comb begin
      if (32'(hash_out.hash) < ice_limit_ff) begin
         hash_code = ncmg_pkg::TILE_ICE;
      end else if (32'(hash_out.hash) < rock_limit_ff) begin
         hash_code = ncmg_pkg::TILE_ROCK;
      end else begin
         hash_code = ncmg_pkg::TILE_WATER;
      end
   end

   // neighbour fetch column c-1+sub, held one above to stay unsigned
   always_comb begin
      fcol   = (CW+1)'(col_ff) + (CW+1)'(sub_ff);
      fvalid = (fcol != '0) && (fcol <= (CW+1)'(ncmg_pkg::MAP_COLUMNS))
            && (frow_ff < (RW+1)'(ncmg_pkg::MAP_ROWS)) && (sub_ff != 2'd3);
      fdata  = rd_ok_ff ? rd_data : ncmg_pkg::TILE_NONE;
   end

   // water count over the window
   always_comb begin
      water_cnt = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            water_cnt = water_cnt + 4'(win_ff[i][j] == ncmg_pkg::TILE_WATER);
         end
      end
      new_tile  = (water_cnt > water_limit_ff) ? ncmg_pkg::TILE_WATER : win_ff[1][1];
      pass_next = 5'(pass_ff) + 5'd1;
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      frow_in      = frow_ff;
      sub_in       = sub_ff;
      pass_in      = pass_ff;
      rd_ok_in     = rd_ok_ff;
      generated_in = generated_ff;
      win_in       = win_ff;
      nrow_in      = nrow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tile_in  = rsp_tile_ff;

      hash_in_valid = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = hash_out.valid;
      wr_addr       = hash_out.addr;
      wr_data       = hash_code;

      case (state_ff)
         ncmg_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == ncmg_pkg::OP_GENERATE) begin
                  seed_in  = req_seed;
                  col_in   = '0;
                  row_in   = '0;
                  state_in = ncmg_pkg::ST_FILL;
               end else if (in_map && generated_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = ncmg_pkg::addr_of(req_column[CW-1:0], req_row[RW-1:0]);
                  state_in = ncmg_pkg::ST_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = ncmg_pkg::REPLY_TILE;
                  rsp_tile_in  = ncmg_pkg::TILE_NONE;
               end
            end
         end
         ncmg_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = ncmg_pkg::REPLY_TILE;
            rsp_tile_in  = rd_data;
            state_in     = ncmg_pkg::ST_IDLE;
         end
         ncmg_pkg::ST_FILL: begin
            hash_in_valid = 1'b1;
            if (row_ff == RW'(ncmg_pkg::MAP_ROWS - 1)) begin
               row_in = '0;
               if (col_ff == CW'(ncmg_pkg::MAP_COLUMNS - 1)) begin
                  state_in = ncmg_pkg::ST_DRAIN;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         ncmg_pkg::ST_DRAIN: begin
            if (!hash_busy) begin
               col_in   = '0;
               row_in   = '0;
               pass_in  = '0;
               state_in = (passes_ff == '0) ? ncmg_pkg::ST_DONE : ncmg_pkg::ST_COL_START;
            end
         end
         ncmg_pkg::ST_COL_START: begin
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  win_in[i][j] = ncmg_pkg::TILE_NONE;
               end
            end
            frow_in  = '0;
            sub_in   = '0;
            row_in   = '0;
            state_in = ncmg_pkg::ST_FETCH;
         end
         ncmg_pkg::ST_FETCH: begin
            // reads in sub 0..2, registered data arrives in the next sub
            rd_en    = fvalid;
            rd_addr  = fvalid ? ncmg_pkg::addr_of(CW'(fcol - 1'b1), frow_ff[RW-1:0]) : '0;
            rd_ok_in = fvalid;
            sub_in   = sub_ff + 1'b1;
            if (sub_ff == 2'd1) begin
               nrow_in[0] = fdata;
            end
            if (sub_ff == 2'd2) begin
               nrow_in[1] = fdata;
            end
            if (sub_ff == 2'd3) begin
               for (int i = 0; i < 3; i++) begin
                  win_in[i][0] = win_ff[i][1];
                  win_in[i][1] = win_ff[i][2];
               end
               win_in[0][2] = nrow_ff[0];
               win_in[1][2] = nrow_ff[1];
               win_in[2][2] = fdata;
               frow_in      = frow_ff + 1'b1;
               state_in     = (frow_ff == '0) ? ncmg_pkg::ST_FETCH : ncmg_pkg::ST_COMPUTE;
            end
         end
         ncmg_pkg::ST_COMPUTE: begin
            wr_en        = 1'b1;
            wr_addr      = ncmg_pkg::addr_of(col_ff, row_ff);
            wr_data      = new_tile;
            win_in[1][1] = new_tile;
            sub_in       = '0;
            if (row_ff == RW'(ncmg_pkg::MAP_ROWS - 1)) begin
               if (col_ff == CW'(ncmg_pkg::MAP_COLUMNS - 1)) begin
                  col_in  = '0;
                  pass_in = pass_next[3:0];
                  state_in = (pass_next == 5'(passes_ff)) ? ncmg_pkg::ST_DONE
                                                          : ncmg_pkg::ST_COL_START;
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = ncmg_pkg::ST_COL_START;
               end
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = ncmg_pkg::ST_FETCH;
            end
         end
         ncmg_pkg::ST_DONE: begin
            generated_in = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_kind_in  = ncmg_pkg::REPLY_DONE;
            rsp_tile_in  = ncmg_pkg::TILE_NONE;
            state_in     = ncmg_pkg::ST_IDLE;
         end
         default: begin
            state_in = ncmg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ncmg_pkg::ST_IDLE;
         generated_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         generated_ff <= generated_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seed_ff     <= seed_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      frow_ff     <= frow_in;
      sub_ff      <= sub_in;
      pass_ff     <= pass_in;
      rd_ok_ff    <= rd_ok_in;
      win_ff      <= win_in;
      nrow_ff     <= nrow_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tile_ff <= rsp_tile_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ice_limit_ff   <= 32'd644245095;
         rock_limit_ff  <= 32'd751619277;
         passes_ff      <= 4'd5;
         water_limit_ff <= 4'd5;
      end else if (csr_write) begin
         case (csr_index)
            ncmg_pkg::REG_ICE_LIMIT:   ice_limit_ff   <= csr_wdata;
            ncmg_pkg::REG_ROCK_LIMIT:  rock_limit_ff  <= csr_wdata;
            ncmg_pkg::REG_PASSES:      passes_ff      <= csr_wdata[3:0];
            ncmg_pkg::REG_WATER_LIMIT: water_limit_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

endmodule

### rtl/ncmg_store.sv
// Tile store: simple dual-port memory, registered read.
`timescale 1ns / 1ps

module ncmg_store (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [ncmg_pkg::ADDR_W-1:0]          wr_addr,
   input  logic [ncmg_pkg::TILE_W-1:0]          wr_data,
   input  logic                                 rd_en,
   input  logic [ncmg_pkg::ADDR_W-1:0]          rd_addr,
   output logic [ncmg_pkg::TILE_W-1:0]          rd_data
);

   logic [ncmg_pkg::TILE_W-1:0] mem [ncmg_pkg::DEPTH];
   logic [ncmg_pkg::TILE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ncmg_hash.sv
// Four-stage pipelined noise hash, one tile per cycle.
`timescale 1ns / 1ps

module ncmg_hash (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [ncmg_pkg::COL_W-1:0]   in_col,
   input  logic [ncmg_pkg::ROW_W-1:0]   in_row,
   input  logic [31:0]                  seed,
   output ncmg_pkg::hash_out_type       hash_out,
   output logic                         busy
);

   logic [3:0]                      v_ff;
   logic [ncmg_pkg::ADDR_W-1:0]     a1_ff, a2_ff, a3_ff, a4_ff;
   logic [31:0]                     n1_ff, n2_ff, n3_ff;
   logic [31:0]                     sq_ff, t_ff, p_ff;
   logic [31:0]                     n0_in, base_in, sum_in;

   always_comb begin
      base_in = 32'(in_col) + 32'(in_row) * ncmg_pkg::HASH_ROW_MUL
              + seed * ncmg_pkg::HASH_SEED_MUL;
      n0_in   = (base_in << ncmg_pkg::HASH_SHIFT) ^ base_in;
      sum_in  = p_ff + ncmg_pkg::HASH_FIN_ADD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], in_valid};
      end
      a1_ff <= ncmg_pkg::addr_of(in_col, in_row);
      n1_ff <= n0_in;
      a2_ff <= a1_ff;
      n2_ff <= n1_ff;
      sq_ff <= n1_ff * n1_ff;
      a3_ff <= a2_ff;
      n3_ff <= n2_ff;
      t_ff  <= sq_ff * ncmg_pkg::HASH_SQ_MUL + ncmg_pkg::HASH_SQ_ADD;
      a4_ff <= a3_ff;
      p_ff  <= n3_ff * t_ff;
   end

   assign hash_out.valid = v_ff[3];
   assign hash_out.addr  = a4_ff;
   assign hash_out.hash  = sum_in[ncmg_pkg::HASH_W-1:0];
   assign busy           = |v_ff;

endmodule
